>>> rtl/owb_pkg.sv
package owb_pkg;

    localparam int TIMER_W         = 10;
    localparam int CFG_IDX_W       = 4;
    localparam int WAIT_HIGH_TICKS = 248;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_DELAY = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOVERY = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_RECOVERY   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_RECOVERY  = 4'd7;

    localparam logic [TIMER_W-1:0] RST_RESET_LOW      = 10'd480;
    localparam logic [TIMER_W-1:0] RST_PRESENCE_DELAY = 10'd70;
    localparam logic [TIMER_W-1:0] RST_RESET_RECOVERY = 10'd410;
    localparam logic [TIMER_W-1:0] RST_SHORT_LOW      = 10'd5;
    localparam logic [TIMER_W-1:0] RST_SAMPLE_DELAY   = 10'd8;
    localparam logic [TIMER_W-1:0] RST_ONE_RECOVERY   = 10'd52;
    localparam logic [TIMER_W-1:0] RST_ZERO_LOW       = 10'd65;
    localparam logic [TIMER_W-1:0] RST_ZERO_RECOVERY  = 10'd5;

    // command codes on the cmd port
    localparam logic [2:0] CMD_CODE_RESET   = 3'd1;
    localparam logic [2:0] CMD_CODE_WRITE   = 3'd2;
    localparam logic [2:0] CMD_CODE_READ    = 3'd3;
    localparam logic [2:0] CMD_CODE_DEPOWER = 3'd4;

    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_RESET,
        KIND_WRITE,
        KIND_READ,
        KIND_DEPOWER
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RWAIT,
        PH_RLOW,
        PH_RPRES,
        PH_RREC,
        PH_WLOW,
        PH_WMID,
        PH_WTAIL,
        PH_RDLOW,
        PH_RDMID,
        PH_RDTAIL
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       sp;
        logic       line;
    } item_t;

    typedef struct packed {
        logic [TIMER_W-1:0] reset_low_time;
        logic [TIMER_W-1:0] presence_delay;
        logic [TIMER_W-1:0] reset_recovery;
        logic [TIMER_W-1:0] short_low_time;
        logic [TIMER_W-1:0] sample_delay;
        logic [TIMER_W-1:0] one_recovery;
        logic [TIMER_W-1:0] zero_low_time;
        logic [TIMER_W-1:0] zero_recovery;
    } cfg_t;

endpackage

>>> rtl/owb_front.sv
module owb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          cmd,
    input  logic [7:0]          data_byte,
    input  logic                strong_power,
    input  logic                line_level,
    output logic                q_valid,
    output owb_pkg::item_t      q_item,
    input  logic                q_pop
);

    owb_pkg::item_t mem_reg [2];
    owb_pkg::item_t item_dec;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;

    // classify the command; unknown codes act as a plain tick
    always_comb
    begin
        item_dec.data = data_byte;
        item_dec.sp   = strong_power;
        item_dec.line = line_level;
        case (cmd)
            owb_pkg::CMD_CODE_RESET:   item_dec.kind = owb_pkg::KIND_RESET;
            owb_pkg::CMD_CODE_WRITE:   item_dec.kind = owb_pkg::KIND_WRITE;
            owb_pkg::CMD_CODE_READ:    item_dec.kind = owb_pkg::KIND_READ;
            owb_pkg::CMD_CODE_DEPOWER: item_dec.kind = owb_pkg::KIND_DEPOWER;
            default:                   item_dec.kind = owb_pkg::KIND_TICK;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");
`endif

endmodule

>>> rtl/owb_engine.sv
module owb_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  owb_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  owb_pkg::item_t      q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                drive_low,
    output logic                drive_high,
    output logic                busy_res,
    output logic                done_res,
    output logic                presence,
    output logic                stuck_low,
    output logic [7:0]          read_data
);

    localparam int TW = owb_pkg::TIMER_W;

    owb_pkg::phase_t phase_reg, phase_next, ph_eff;
    logic [TW-1:0]   timer_reg, timer_next, tmr_eff, tmr_inc, len;
    logic [2:0]      bit_cnt_reg, bit_cnt_next, bc_eff;
    logic [7:0]      shift_reg, shift_next, shift_eff;
    logic            preq_reg, preq_next, preq_eff;
    logic            shon_reg, shon_next, shon_eff;
    logic            pres_reg, pres_next, pres_eff;
    logic            stuck_reg, stuck_next, stuck_eff;
    logic [7:0]      last_read_reg, last_read_next;
    logic            depower, bitv, bit_last, over, done;
    logic            dlow, dhigh, busy;

    logic            out_valid_reg;
    logic            drive_low_reg, drive_high_reg, busy_reg, done_reg;

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    // command start, only taken while idle
    always_comb
    begin
        ph_eff    = phase_reg;
        tmr_eff   = timer_reg;
        shift_eff = shift_reg;
        bc_eff    = bit_cnt_reg;
        preq_eff  = preq_reg;
        shon_eff  = shon_reg;
        pres_eff  = pres_reg;
        stuck_eff = stuck_reg;
        depower   = 1'b0;
        if (phase_reg == owb_pkg::PH_IDLE)
        begin
            case (q_item.kind)
                owb_pkg::KIND_RESET:
                begin
                    shon_eff  = 1'b0;
                    pres_eff  = 1'b0;
                    stuck_eff = 1'b0;
                    ph_eff    = owb_pkg::PH_RWAIT;
                    tmr_eff   = '0;
                end
                owb_pkg::KIND_WRITE:
                begin
                    shon_eff  = 1'b0;
                    shift_eff = q_item.data;
                    preq_eff  = q_item.sp;
                    bc_eff    = 3'd0;
                    ph_eff    = owb_pkg::PH_WLOW;
                    tmr_eff   = '0;
                end
                owb_pkg::KIND_READ:
                begin
                    shon_eff  = 1'b0;
                    shift_eff = 8'd0;
                    bc_eff    = 3'd0;
                    ph_eff    = owb_pkg::PH_RDLOW;
                    tmr_eff   = '0;
                end
                owb_pkg::KIND_DEPOWER:
                begin
                    shon_eff = 1'b0;
                    depower  = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign bitv     = shift_eff[bc_eff];
    assign bit_last = (bc_eff == 3'd7);

    always_comb
    begin
        case (ph_eff)
            owb_pkg::PH_RWAIT:  len = TW'(owb_pkg::WAIT_HIGH_TICKS);
            owb_pkg::PH_RLOW:   len = cfg.reset_low_time;
            owb_pkg::PH_RPRES:  len = cfg.presence_delay;
            owb_pkg::PH_RREC:   len = cfg.reset_recovery;
            owb_pkg::PH_WLOW:   len = bitv ? cfg.short_low_time : cfg.zero_low_time;
            owb_pkg::PH_WMID:   len = cfg.sample_delay;
            owb_pkg::PH_WTAIL:  len = bitv ? cfg.one_recovery : cfg.zero_recovery;
            owb_pkg::PH_RDLOW:  len = cfg.short_low_time;
            owb_pkg::PH_RDMID:  len = cfg.sample_delay;
            owb_pkg::PH_RDTAIL: len = cfg.one_recovery;
            default:            len = '0;
        endcase
    end

    // a zero length or a timer wrap both end the phase
    assign tmr_inc = tmr_eff + 1'b1;
    assign over    = (tmr_inc >= len) || (tmr_inc == '0);

    // next state
    always_comb
    begin
        phase_next     = ph_eff;
        timer_next     = tmr_inc;
        bit_cnt_next   = bc_eff;
        shift_next     = shift_eff;
        preq_next      = preq_eff;
        shon_next      = shon_eff;
        pres_next      = pres_eff;
        stuck_next     = stuck_eff;
        last_read_next = last_read_reg;
        done           = depower;
        case (ph_eff)
            owb_pkg::PH_RWAIT:
            begin
                if (q_item.line)
                begin
                    phase_next = owb_pkg::PH_RLOW;
                    timer_next = '0;
                end
                else if (over)
                begin
                    stuck_next = 1'b1;
                    pres_next  = 1'b0;
                    phase_next = owb_pkg::PH_IDLE;
                    timer_next = '0;
                    done       = 1'b1;
                end
            end
            owb_pkg::PH_RLOW:
            begin
                if (over)
                begin
                    phase_next = owb_pkg::PH_RPRES;
                    timer_next = '0;
                end
            end
            owb_pkg::PH_RPRES:
            begin
                if (over)
                begin
                    pres_next  = ~q_item.line;
                    phase_next = owb_pkg::PH_RREC;
                    timer_next = '0;
                end
            end
            owb_pkg::PH_RREC:
            begin
                if (over)
                begin
                    phase_next = owb_pkg::PH_IDLE;
                    timer_next = '0;
                    done       = 1'b1;
                end
            end
            owb_pkg::PH_WLOW:
            begin
                if (over)
                begin
                    if (bit_last && preq_eff)
                    begin
                        shon_next = 1'b1;
                    end
                    phase_next = bitv ? owb_pkg::PH_WMID : owb_pkg::PH_WTAIL;
                    timer_next = '0;
                end
            end
            owb_pkg::PH_WMID:
            begin
                if (over)
                begin
                    phase_next = owb_pkg::PH_WTAIL;
                    timer_next = '0;
                end
            end
            owb_pkg::PH_WTAIL:
            begin
                if (over)
                begin
                    timer_next = '0;
                    if (bit_last)
                    begin
                        phase_next = owb_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        bit_cnt_next = bc_eff + 3'd1;
                        phase_next   = owb_pkg::PH_WLOW;
                    end
                end
            end
            owb_pkg::PH_RDLOW:
            begin
                if (over)
                begin
                    phase_next = owb_pkg::PH_RDMID;
                    timer_next = '0;
                end
            end
            owb_pkg::PH_RDMID:
            begin
                if (over)
                begin
                    shift_next = {q_item.line, shift_eff[7:1]};
                    phase_next = owb_pkg::PH_RDTAIL;
                    timer_next = '0;
                end
            end
            owb_pkg::PH_RDTAIL:
            begin
                if (over)
                begin
                    timer_next = '0;
                    if (bit_last)
                    begin
                        last_read_next = shift_eff;
                        phase_next     = owb_pkg::PH_IDLE;
                        done           = 1'b1;
                    end
                    else
                    begin
                        bit_cnt_next = bc_eff + 3'd1;
                        phase_next   = owb_pkg::PH_RDLOW;
                    end
                end
            end
            default:
            begin
                phase_next = owb_pkg::PH_IDLE;
                timer_next = '0;
            end
        endcase
    end

    // per tick outputs
    always_comb
    begin
        dlow  = (ph_eff == owb_pkg::PH_RLOW) || (ph_eff == owb_pkg::PH_WLOW) ||
                (ph_eff == owb_pkg::PH_RDLOW);
        dhigh = shon_eff && !dlow;
        busy  = depower || (ph_eff != owb_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= owb_pkg::PH_IDLE;
            timer_reg     <= '0;
            bit_cnt_reg   <= 3'd0;
            shift_reg     <= 8'd0;
            preq_reg      <= 1'b0;
            shon_reg      <= 1'b0;
            pres_reg      <= 1'b0;
            stuck_reg     <= 1'b0;
            last_read_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                timer_reg     <= timer_next;
                bit_cnt_reg   <= bit_cnt_next;
                shift_reg     <= shift_next;
                preq_reg      <= preq_next;
                shon_reg      <= shon_next;
                pres_reg      <= pres_next;
                stuck_reg     <= stuck_next;
                last_read_reg <= last_read_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each item
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            drive_low_reg  <= dlow;
            drive_high_reg <= dhigh;
            busy_reg       <= busy;
            done_reg       <= done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign drive_low  = drive_low_reg;
    assign drive_high = drive_high_reg;
    assign busy_res   = busy_reg;
    assign done_res   = done_reg;
    assign presence   = pres_reg;
    assign stuck_low  = stuck_reg;
    assign read_data  = last_read_reg;

`ifndef ASSERT_OFF
    a_no_contention: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(drive_low_reg && drive_high_reg))
        else $error("line driven low and high together");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> busy_reg)
        else $error("done without busy");

    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && phase_reg == owb_pkg::PH_IDLE && q_item.kind == owb_pkg::KIND_TICK)
        |=> phase_reg == owb_pkg::PH_IDLE)
        else $error("plain tick left idle");

    a_bit_step: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && bit_cnt_next != bit_cnt_reg) |->
        (phase_reg == owb_pkg::PH_WTAIL || phase_reg == owb_pkg::PH_RDTAIL ||
         phase_reg == owb_pkg::PH_IDLE))
        else $error("bit count moved outside a slot end or start");
`endif

endmodule

>>> rtl/onewire_bus_master.sv
// 1-Wire bus master. Each input item is one microsecond tick carrying the
// sampled wire level and, while the master is idle, optionally a command
// (reset with presence detect, write byte LSB first with optional strong
// pull-up, read byte, depower); each item gives exactly one result with the
// line drive, busy and done flags, the last reset status and the last read
// byte. Items are taken into a two-entry queue and run through a phase
// sequencer that does one tick per clock, so the sustained rate is one item
// per cycle while results are taken. The queue entry written when an item
// is accepted feeds the sequencer, whose result register loads when that
// item is popped. A stalled result holds the queue, and in_ready drops
// once both entries are full. Timing registers are written through the
// cfg port, which is always ready, and should only be changed while no
// operation is in progress.
module onewire_bus_master (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      cmd,
    input  logic [7:0]                      data_byte,
    input  logic                            strong_power,
    input  logic                            line_level,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            drive_low,
    output logic                            drive_high,
    output logic                            busy_res,
    output logic                            done_res,
    output logic                            presence,
    output logic                            stuck_low,
    output logic [7:0]                      read_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [owb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [owb_pkg::TIMER_W-1:0]     cfg_data
);

    owb_pkg::cfg_t  cfg_reg;
    owb_pkg::item_t q_item;
    logic           q_valid;
    logic           q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time <= owb_pkg::RST_RESET_LOW;
            cfg_reg.presence_delay <= owb_pkg::RST_PRESENCE_DELAY;
            cfg_reg.reset_recovery <= owb_pkg::RST_RESET_RECOVERY;
            cfg_reg.short_low_time <= owb_pkg::RST_SHORT_LOW;
            cfg_reg.sample_delay   <= owb_pkg::RST_SAMPLE_DELAY;
            cfg_reg.one_recovery   <= owb_pkg::RST_ONE_RECOVERY;
            cfg_reg.zero_low_time  <= owb_pkg::RST_ZERO_LOW;
            cfg_reg.zero_recovery  <= owb_pkg::RST_ZERO_RECOVERY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                owb_pkg::REG_RESET_LOW:      cfg_reg.reset_low_time <= cfg_data;
                owb_pkg::REG_PRESENCE_DELAY: cfg_reg.presence_delay <= cfg_data;
                owb_pkg::REG_RESET_RECOVERY: cfg_reg.reset_recovery <= cfg_data;
                owb_pkg::REG_SHORT_LOW:      cfg_reg.short_low_time <= cfg_data;
                owb_pkg::REG_SAMPLE_DELAY:   cfg_reg.sample_delay   <= cfg_data;
                owb_pkg::REG_ONE_RECOVERY:   cfg_reg.one_recovery   <= cfg_data;
                owb_pkg::REG_ZERO_LOW:       cfg_reg.zero_low_time  <= cfg_data;
                owb_pkg::REG_ZERO_RECOVERY:  cfg_reg.zero_recovery  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    owb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .strong_power (strong_power),
        .line_level   (line_level),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    owb_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive_low  (drive_low),
        .drive_high (drive_high),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .presence   (presence),
        .stuck_low  (stuck_low),
        .read_data  (read_data)
    );

endmodule
